[hdl/sme_pkg.sv]
// Shared constants, codes and field widths of the stack machine executor.
package sme_pkg;
  localparam int STACK_DEPTH   = 2048;
  localparam int STACK_RESERVE = 20;
  localparam int DISPLAY_DEPTH = 8;
  localparam int CODE_DEPTH    = 256;
  localparam int SA_W          = $clog2(STACK_DEPTH);
  localparam int DL_W          = $clog2(DISPLAY_DEPTH);
  localparam int PC_W          = $clog2(CODE_DEPTH);
  localparam int STACK_LIMIT   = STACK_DEPTH - STACK_RESERVE;

  typedef enum logic [3:0] {
    OP_LIT = 4'd0, OP_OPR = 4'd1, OP_LOD = 4'd2, OP_STO = 4'd3, OP_CAL = 4'd4,
    OP_RET = 4'd5, OP_ICT = 4'd6, OP_JMP = 4'd7, OP_JPC = 4'd8
  } op_code_t;

  typedef enum logic [3:0] {
    ALU_NEG = 4'd0, ALU_ADD = 4'd1, ALU_SUB = 4'd2, ALU_MUL = 4'd3,
    ALU_DIV = 4'd4, ALU_ODD = 4'd5, ALU_EQ = 4'd6, ALU_LS = 4'd7,
    ALU_GR = 4'd8, ALU_NEQ = 4'd9, ALU_LSEQ = 4'd10, ALU_GREQ = 4'd11,
    ALU_WRT = 4'd12, ALU_WRL = 4'd13
  } alu_op_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0, FLT_OVERFLOW = 2'd1, FLT_DIV_ZERO = 2'd2
  } fault_t;
endpackage

[hdl/sme_in_if.sv]
// Instruction channel: valid, ready and one instruction's fields.
interface sme_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op_code;
  logic [3:0]         alu_op;
  logic [2:0]         frame_level;
  logic signed [31:0] operand;
  modport source (output valid, op_code, alu_op, frame_level, operand, input ready);
  modport sink (input valid, op_code, alu_op, frame_level, operand, output ready);
endinterface

[hdl/sme_out_if.sv]
// Result channel: valid, ready and one result's fields.
interface sme_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         next_pc;
  logic               halted;
  logic               out_valid;
  logic               out_newline;
  logic signed [31:0] out_value;
  logic [1:0]         fault;
  modport source (output valid, next_pc, halted, out_valid, out_newline, out_value, fault,
                  input ready);
  modport sink (input valid, next_pc, halted, out_valid, out_newline, out_value, fault,
                output ready);
endinterface

[hdl/stack_machine_executor.sv]
// Stack machine executor: runs one instruction per transaction under a small sequencer.
// One instruction is taken at a time; in_ch.ready is high only while the sequencer idles.
// After acceptance an instruction runs from decode through the states of its kind to a
// done state; ret and the binary operators (div by zero included) read their cells one
// after another, and div with a nonzero divisor then iterates, one quotient bit a cycle
// in the divider. The sequence is set by the single read port of the data stack memory,
// whose read data is registered. A result waits in an output register; the next
// instruction is accepted meanwhile and its completion holds until the result is taken.
// Stack cells 0 and 1 read as zero after reset until written; no clearing pass is made.
module stack_machine_executor
  import sme_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_LOD, S_STO, S_CAL, S_RET1, S_RET2, S_RET3, S_JPC, S_UN,
    S_BIN1, S_BIN2, S_DIV, S_ALU, S_DONE
  } state_t;

  state_t             state_r;
  logic [3:0]         op_r, alu_r;
  logic [DL_W-1:0]    lvl_r;
  logic signed [31:0] opnd_r;
  logic [SA_W-1:0]    top_r;
  logic [PC_W-1:0]    pc_r;
  logic [SA_W-1:0]    disp_r [DISPLAY_DEPTH];
  logic [31:0]        a_r, b_r;
  logic [31:0]        quo_r, rem_r;
  logic [4:0]         cnt_r;
  logic               pv_r, nl_r;
  logic [31:0]        pval_r;
  logic [1:0]         flt_r;

  logic               ov_r, onl_r, ohalt_r, oval_r;
  logic [7:0]         opc_r;
  logic [31:0]        ovalue_r;
  logic [1:0]         ofault_r;

  logic [31:0]        mem [STACK_DEPTH];
  logic [31:0]        mem_q_r;
  logic [SA_W-1:0]    rd_addr_r;
  logic [1:0]         cell_ok_r;
  logic [31:0]        rdata;

  logic               we_c;
  logic [SA_W-1:0]    waddr_c, raddr_c;
  logic [31:0]        wdata_c;

  logic [DL_W-1:0]    lev_c;
  logic [SA_W-1:0]    base_c, eff_c, topm1_c, rtop_c;
  logic signed [33:0] nt_c;
  logic [31:0]        alu_res_c, absa_c, absb_c, quo_c;
  logic [32:0]        trial_c;
  logic [31:0]        rem_sh_c;
  logic               out_free;

  assign lev_c    = lvl_r + DL_W'(1);
  assign base_c   = disp_r[lvl_r];
  assign eff_c    = base_c + opnd_r[SA_W-1:0];
  assign topm1_c  = top_r - SA_W'(1);
  assign rtop_c   = base_c - opnd_r[SA_W-1:0];
  assign nt_c     = $signed({2'b00, 21'd0, top_r}) + 34'(opnd_r);
  assign absb_c   = b_r[31] ? (32'd0 - b_r) : b_r;
  assign absa_c   = rdata[31] ? (32'd0 - rdata) : rdata;
  assign rem_sh_c = {rem_r[30:0], quo_r[31]};
  assign trial_c  = {rem_r[31:0], quo_r[31]} - {1'b0, absb_c};
  assign quo_c    = (a_r[31] ^ b_r[31]) ? (32'd0 - quo_r) : quo_r;
  assign out_free = !ov_r || out_ch.ready;
  assign rdata    = (rd_addr_r[SA_W-1:1] == '0 && !cell_ok_r[rd_addr_r[0]]) ? 32'd0
                                                                             : mem_q_r;

  always_comb begin
    case (alu_r)
      ALU_ADD:  alu_res_c = a_r + b_r;
      ALU_SUB:  alu_res_c = a_r - b_r;
      ALU_MUL:  alu_res_c = a_r * b_r;
      ALU_DIV:  alu_res_c = (b_r == 32'd0) ? 32'd0 : quo_c;
      ALU_EQ:   alu_res_c = {31'd0, a_r == b_r};
      ALU_LS:   alu_res_c = {31'd0, $signed(a_r) < $signed(b_r)};
      ALU_GR:   alu_res_c = {31'd0, $signed(a_r) > $signed(b_r)};
      ALU_NEQ:  alu_res_c = {31'd0, a_r != b_r};
      ALU_LSEQ: alu_res_c = {31'd0, $signed(a_r) <= $signed(b_r)};
      ALU_GREQ: alu_res_c = {31'd0, $signed(a_r) >= $signed(b_r)};
      default:  alu_res_c = 32'd0;
    endcase
  end

  always_comb begin
    we_c    = 1'b0;
    waddr_c = top_r;
    wdata_c = 32'd0;
    raddr_c = topm1_c;
    case (state_r)
      S_DEC: begin
        case (op_r)
          OP_LIT: begin
            we_c    = 1'b1;
            wdata_c = opnd_r;
          end
          OP_LOD: raddr_c = eff_c;
          OP_CAL: begin
            we_c    = 1'b1;
            wdata_c = 32'(disp_r[lev_c]);
          end
          default: raddr_c = topm1_c;
        endcase
      end
      S_LOD: begin
        we_c    = 1'b1;
        wdata_c = rdata;
      end
      S_STO: begin
        we_c    = 1'b1;
        waddr_c = eff_c;
        wdata_c = rdata;
      end
      S_CAL: begin
        we_c    = 1'b1;
        waddr_c = top_r + SA_W'(1);
        wdata_c = 32'(pc_r);
      end
      S_RET1: raddr_c = base_c;
      S_RET2: raddr_c = base_c + SA_W'(1);
      S_RET3: begin
        we_c    = 1'b1;
        waddr_c = rtop_c;
        wdata_c = a_r;
      end
      S_UN: begin
        we_c    = (alu_r == ALU_NEG) || (alu_r == ALU_ODD);
        waddr_c = topm1_c;
        wdata_c = (alu_r == ALU_NEG) ? (32'd0 - rdata) : (rdata & 32'd1);
      end
      S_ALU: begin
        we_c    = 1'b1;
        waddr_c = topm1_c;
        wdata_c = alu_res_c;
      end
      default: we_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    mem_q_r   <= mem[raddr_c];
    rd_addr_r <= raddr_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_ok_r <= 2'b00;
    end else if (we_c && waddr_c[SA_W-1:1] == '0) begin
      cell_ok_r[waddr_c[0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r   <= '0;
      pc_r    <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < DISPLAY_DEPTH; i++) begin
        disp_r[i] <= '0;
      end
    end else begin
      if (ov_r && out_ch.ready && state_r != S_DONE) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op_code;
            alu_r   <= in_ch.alu_op;
            lvl_r   <= in_ch.frame_level[DL_W-1:0];
            opnd_r  <= in_ch.operand;
            pc_r    <= pc_r + PC_W'(1);
            pv_r    <= 1'b0;
            nl_r    <= 1'b0;
            pval_r  <= 32'd0;
            flt_r   <= FLT_NONE;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          case (op_r)
            OP_LIT: begin
              top_r   <= top_r + SA_W'(1);
              state_r <= S_DONE;
            end
            OP_LOD: state_r <= S_LOD;
            OP_STO: begin
              top_r   <= topm1_c;
              state_r <= S_STO;
            end
            OP_CAL: state_r <= S_CAL;
            OP_RET: state_r <= S_RET1;
            OP_ICT: begin
              if (nt_c >= 34'(STACK_LIMIT) || nt_c < 0) begin
                flt_r <= FLT_OVERFLOW;
              end else begin
                top_r <= nt_c[SA_W-1:0];
              end
              state_r <= S_DONE;
            end
            OP_JMP: begin
              pc_r    <= opnd_r[PC_W-1:0];
              state_r <= S_DONE;
            end
            OP_JPC: begin
              top_r   <= topm1_c;
              state_r <= S_JPC;
            end
            OP_OPR: begin
              case (alu_r) inside
                ALU_NEG, ALU_ODD, ALU_WRT: state_r <= S_UN;
                [ALU_ADD:ALU_DIV], [ALU_EQ:ALU_GREQ]: begin
                  top_r   <= topm1_c;
                  state_r <= S_BIN1;
                end
                ALU_WRL: begin
                  pv_r    <= 1'b1;
                  nl_r    <= 1'b1;
                  state_r <= S_DONE;
                end
                default: state_r <= S_DONE;
              endcase
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_LOD: begin
          top_r   <= top_r + SA_W'(1);
          state_r <= S_DONE;
        end
        S_STO: state_r <= S_DONE;
        S_CAL: begin
          disp_r[lev_c] <= top_r;
          pc_r          <= opnd_r[PC_W-1:0];
          state_r       <= S_DONE;
        end
        S_RET1: begin
          a_r     <= rdata;
          state_r <= S_RET2;
        end
        S_RET2: begin
          b_r     <= rdata;
          state_r <= S_RET3;
        end
        S_RET3: begin
          state_r <= S_DONE;
          pc_r    <= rdata[PC_W-1:0];
          disp_r[lvl_r] <= b_r[SA_W-1:0];
          top_r   <= rtop_c + SA_W'(1);
        end
        S_JPC: begin
          if (rdata == 32'd0) begin
            pc_r <= opnd_r[PC_W-1:0];
          end
          state_r <= S_DONE;
        end
        S_UN: begin
          if (alu_r == ALU_WRT) begin
            pv_r   <= 1'b1;
            pval_r <= rdata;
            top_r  <= topm1_c;
          end
          state_r <= S_DONE;
        end
        S_BIN1: begin
          b_r     <= rdata;
          state_r <= S_BIN2;
        end
        S_BIN2: begin
          a_r <= rdata;
          if (alu_r == ALU_DIV && b_r != 32'd0) begin
            quo_r   <= absa_c;
            rem_r   <= 32'd0;
            cnt_r   <= 5'd31;
            state_r <= S_DIV;
          end else begin
            if (alu_r == ALU_DIV) begin
              flt_r <= FLT_DIV_ZERO;
            end
            state_r <= S_ALU;
          end
        end
        S_DIV: begin
          if (!trial_c[32]) begin
            rem_r <= trial_c[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh_c;
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= S_ALU;
          end
        end
        S_ALU: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            opc_r    <= 8'(pc_r);
            ohalt_r  <= (pc_r == '0);
            oval_r   <= pv_r;
            onl_r    <= nl_r;
            ovalue_r <= pval_r;
            ofault_r <= flt_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.next_pc     = opc_r;
  assign out_ch.halted      = ohalt_r;
  assign out_ch.out_valid   = oval_r;
  assign out_ch.out_newline = onl_r;
  assign out_ch.out_value   = ovalue_r;
  assign out_ch.fault       = ofault_r;
endmodule

[hdl/sme_checker.sv]
// Port checker for the stack machine executor and its bind.
module sme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  next_pc,
  input logic        halted,
  input logic        print_valid,
  input logic        print_newline,
  input logic [31:0] print_value,
  input logic [1:0]  fault
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(print_value))
    else $error("result changed while stalled");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> halted == (next_pc == 8'd0))
    else $error("halted disagrees with next_pc");
  a_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && print_newline |-> print_valid && print_value == 32'd0)
    else $error("newline without print");
  a_fault_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault != 2'd0 |-> !print_valid)
    else $error("fault on a print transaction");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two transactions back to back");
endmodule

bind stack_machine_executor sme_checker u_sme_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .next_pc       (out_ch.next_pc),
  .halted        (out_ch.halted),
  .print_valid   (out_ch.out_valid),
  .print_newline (out_ch.out_newline),
  .print_value   (out_ch.out_value),
  .fault         (out_ch.fault)
);

[tb/tb_stack_machine_executor.sv]
// Testbench of the stack machine executor: instruction streams checked against a predictor.
module tb_stack_machine_executor;
  import sme_pkg::*;

  typedef struct {
    logic [3:0]  op;
    logic [3:0]  alu;
    logic [2:0]  lvl;
    logic [31:0] opnd;
  } instr_t;

  typedef struct {
    logic [7:0]  next_pc;
    logic        halted;
    logic        out_valid;
    logic        out_newline;
    logic [31:0] out_value;
    fault_t      fault;
  } step_result_t;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;

  sme_in_if  in_if();
  sme_out_if out_if();

  stack_machine_executor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [31:0]  stack_mem [STACK_DEPTH];
  bit           cell_written [STACK_DEPTH];
  int           frame_base [DISPLAY_DEPTH];
  int           top_ptr;
  logic [7:0]   pc_reg;
  step_result_t pending_results [$];
  int           errors;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int wrap_addr(longint a);
    longint r;
    r = a % STACK_DEPTH;
    if (r < 0) r += STACK_DEPTH;
    return int'(r);
  endfunction

  function automatic bit unwritten(longint a);
    return !cell_written[wrap_addr(a)];
  endfunction

  function automatic bit reads_unwritten(instr_t it);
    int base;
    base = frame_base[it.lvl];
    case (it.op)
      OP_OPR: begin
        case (it.alu)
          ALU_NEG, ALU_ODD, ALU_WRT: return unwritten(top_ptr - 1);
          ALU_WRL: return 1'b0;
          default: begin
            if (it.alu > ALU_WRL) return 1'b0;
            return unwritten(top_ptr - 1) || unwritten(top_ptr - 2);
          end
        endcase
      end
      OP_LOD: return unwritten(longint'(base) + longint'($signed(it.opnd)));
      OP_STO, OP_JPC: return unwritten(top_ptr - 1);
      OP_RET: return unwritten(top_ptr - 1) || unwritten(base) || unwritten(base + 1);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_cell(logic [31:0] v);
    stack_mem[top_ptr] = v;
    cell_written[top_ptr] = 1'b1;
    top_ptr = wrap_addr(top_ptr + 1);
  endfunction

  function automatic logic [31:0] pop_cell();
    top_ptr = wrap_addr(top_ptr - 1);
    return stack_mem[top_ptr];
  endfunction

  function automatic step_result_t execute_instr(instr_t it);
    step_result_t r;
    logic [31:0] a, b, tmp;
    int idx, lev, base;
    longint sa, sb, nt;
    r = '{fault: FLT_NONE, default: '0};
    pc_reg = pc_reg + 8'd1;
    case (it.op)
      OP_LIT: push_cell(it.opnd);
      OP_LOD: push_cell(stack_mem[wrap_addr(longint'(frame_base[it.lvl]) +
                                           longint'($signed(it.opnd)))]);
      OP_STO: begin
        tmp = pop_cell();
        idx = wrap_addr(longint'(frame_base[it.lvl]) + longint'($signed(it.opnd)));
        stack_mem[idx] = tmp;
        cell_written[idx] = 1'b1;
      end
      OP_CAL: begin
        lev = (it.lvl + 1) % DISPLAY_DEPTH;
        stack_mem[top_ptr] = frame_base[lev];
        cell_written[top_ptr] = 1'b1;
        idx = wrap_addr(top_ptr + 1);
        stack_mem[idx] = {24'd0, pc_reg};
        cell_written[idx] = 1'b1;
        frame_base[lev] = top_ptr;
        pc_reg = it.opnd[7:0];
      end
      OP_RET: begin
        tmp = pop_cell();
        base = frame_base[it.lvl];
        frame_base[it.lvl] = wrap_addr(longint'($signed(stack_mem[base])));
        pc_reg = stack_mem[wrap_addr(base + 1)][7:0];
        top_ptr = wrap_addr(longint'(base) - longint'($signed(it.opnd)));
        push_cell(tmp);
      end
      OP_ICT: begin
        nt = longint'(top_ptr) + longint'($signed(it.opnd));
        if (nt >= STACK_LIMIT || nt < 0) r.fault = FLT_OVERFLOW;
        else top_ptr = int'(nt);
      end
      OP_JMP: pc_reg = it.opnd[7:0];
      OP_JPC: begin
        if (pop_cell() == 32'd0) pc_reg = it.opnd[7:0];
      end
      OP_OPR: begin
        idx = wrap_addr(top_ptr - 1);
        case (it.alu)
          ALU_NEG: stack_mem[idx] = 32'd0 - stack_mem[idx];
          ALU_ODD: stack_mem[idx] = stack_mem[idx] & 32'd1;
          ALU_WRT: begin
            r.out_valid = 1'b1;
            r.out_value = pop_cell();
          end
          ALU_WRL: begin
            r.out_valid = 1'b1;
            r.out_newline = 1'b1;
          end
          default: begin
            if (it.alu <= ALU_GREQ) begin
              b = pop_cell();
              idx = wrap_addr(top_ptr - 1);
              a = stack_mem[idx];
              sa = longint'($signed(a));
              sb = longint'($signed(b));
              case (it.alu)
                ALU_ADD: a = a + b;
                ALU_SUB: a = a - b;
                ALU_MUL: a = a * b;
                ALU_DIV: begin
                  if (sb == 0) begin
                    a = 32'd0;
                    r.fault = FLT_DIV_ZERO;
                  end else begin
                    nt = sa / sb;
                    a = nt[31:0];
                  end
                end
                ALU_EQ:   a = {31'd0, sa == sb};
                ALU_LS:   a = {31'd0, sa < sb};
                ALU_GR:   a = {31'd0, sa > sb};
                ALU_NEQ:  a = {31'd0, sa != sb};
                ALU_LSEQ: a = {31'd0, sa <= sb};
                default:  a = {31'd0, sa >= sb};
              endcase
              stack_mem[idx] = a;
            end
          end
        endcase
      end
      default: ;
    endcase
    r.next_pc = pc_reg;
    r.halted = (pc_reg == 8'd0);
    return r;
  endfunction

  task automatic send_instr(instr_t it);
    if (reads_unwritten(it)) begin
      it.op = OP_LIT;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.op_code = it.op;
    in_if.alu_op = it.alu;
    in_if.frame_level = it.lvl;
    in_if.operand = it.opnd;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(execute_instr(it));
  endtask

  task automatic send_fields(logic [3:0] op, logic [3:0] alu, logic [2:0] lvl, logic [31:0] v);
    instr_t it;
    it = '{op: op, alu: alu, lvl: lvl, opnd: v};
    send_instr(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_fields(OP_LIT, 4'd0, 3'd0, 32'h7fff_ffff);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'h8000_0000);
    send_fields(OP_OPR, ALU_ADD, 3'd0, 32'd0);
    send_fields(OP_OPR, ALU_NEG, 3'd7, 32'd0);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'd0);
    send_fields(OP_OPR, ALU_DIV, 3'd0, 32'd0);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'h8000_0000);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'hffff_ffff);
    send_fields(OP_OPR, ALU_DIV, 3'd0, 32'd0);
    send_fields(OP_OPR, ALU_WRT, 3'd0, 32'd0);
    send_fields(OP_OPR, ALU_WRL, 3'd0, 32'd0);
    send_fields(OP_OPR, 4'd14, 3'd0, 32'd0);
    send_fields(OP_OPR, 4'd15, 3'd0, 32'd0);
    send_fields(4'd9, 4'd0, 3'd0, 32'd0);
    send_fields(4'd15, 4'd15, 3'd7, 32'hffff_ffff);
    send_fields(OP_ICT, 4'd0, 3'd0, 32'd5000);
    send_fields(OP_ICT, 4'd0, 3'd0, 32'h8000_0000);
    send_fields(OP_ICT, 4'd0, 3'd0, 32'd2);
    send_fields(OP_STO, 4'd0, 3'd0, 32'd3);
    send_fields(OP_LOD, 4'd0, 3'd0, 32'd3);
    send_fields(OP_JPC, 4'd0, 3'd0, 32'd40);
    send_fields(OP_JMP, 4'd0, 3'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_alu_ops();
    for (int op = 0; op < 16; op++) begin
      send_fields(OP_LIT, 4'd0, 3'd0, $urandom());
      send_fields(OP_LIT, 4'd0, 3'd0, (op == ALU_DIV) ? 32'd0 : $urandom_range(7));
      send_fields(OP_OPR, op[3:0], 3'($urandom_range(7)), $urandom());
    end
    drain_results();
  endtask

  task automatic test_call_return();
    send_fields(OP_LIT, 4'd0, 3'd0, 32'd11);
    send_fields(OP_CAL, 4'd0, 3'd0, 32'd100);
    send_fields(OP_ICT, 4'd0, 3'd0, 32'd3);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'd7);
    send_fields(OP_STO, 4'd0, 3'd1, 32'd2);
    send_fields(OP_LOD, 4'd0, 3'd1, 32'd2);
    send_fields(OP_CAL, 4'd0, 3'd7, 32'h0000_01ff);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'd9);
    send_fields(OP_RET, 4'd0, 3'd0, 32'd0);
    send_fields(OP_RET, 4'd0, 3'd1, 32'd1);
    send_fields(OP_LIT, 4'd0, 3'd0, 32'd0);
    send_fields(OP_JPC, 4'd0, 3'd0, 32'd0);
    drain_results();
  endtask

  function automatic instr_t random_instr();
    instr_t it;
    int pick;
    pick = $urandom_range(99);
    it.alu = 4'($urandom_range(15));
    it.lvl = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
    it.opnd = $urandom();
    if (pick < 30) begin
      it.op = OP_LIT;
      if ($urandom_range(2) == 0) it.opnd = 32'($signed($urandom_range(8)) - 4);
    end else if (pick < 62) begin
      it.op = OP_OPR;
      it.alu = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(13));
    end else if (pick < 70) begin
      it.op = OP_LOD;
      it.opnd = 32'($signed($urandom_range(8)) - 4);
    end else if (pick < 78) begin
      it.op = OP_STO;
      it.opnd = 32'($signed($urandom_range(8)) - 4);
    end else if (pick < 83) begin
      it.op = OP_CAL;
    end else if (pick < 88) begin
      it.op = OP_RET;
      it.opnd = $urandom_range(3);
    end else if (pick < 92) begin
      it.op = OP_ICT;
      if ($urandom_range(9) != 0) it.opnd = 32'($signed($urandom_range(6)) - 3);
    end else if (pick < 95) begin
      it.op = OP_JMP;
    end else if (pick < 98) begin
      it.op = OP_JPC;
    end else begin
      it.op = 4'($urandom_range(15, 9));
    end
    return it;
  endfunction

  task automatic test_random_stream(int idle_pct, int stall_pct, int count);
    instr_t it;
    int tries;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      tries = 0;
      do begin
        it = random_instr();
        tries++;
      end while (reads_unwritten(it) && tries < 20);
      if ($urandom_range(99) == 0) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_instr(it);
    end
    drain_results();
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    step_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: next_pc=%0d", out_if.next_pc);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.next_pc !== exp_r.next_pc || out_if.halted !== exp_r.halted ||
            out_if.out_valid !== exp_r.out_valid || out_if.out_newline !== exp_r.out_newline ||
            out_if.out_value !== exp_r.out_value || out_if.fault !== exp_r.fault) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp pc=%0d h=%0b v=%0b nl=%0b val=%0d f=%0d",
                      " | got pc=%0d h=%0b v=%0b nl=%0b val=%0d f=%0d"},
                     exp_r.next_pc, exp_r.halted, exp_r.out_valid, exp_r.out_newline,
                     $signed(exp_r.out_value), exp_r.fault, out_if.next_pc, out_if.halted,
                     out_if.out_valid, out_if.out_newline, out_if.out_value, out_if.fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stack_machine_executor verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    top_ptr = 0;
    pc_reg = 8'd0;
    foreach (stack_mem[i]) begin
      stack_mem[i] = 32'd0;
      cell_written[i] = (i < 2);
    end
    foreach (frame_base[i]) frame_base[i] = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op_code = 4'd0;
    in_if.alu_op = 4'd0;
    in_if.frame_level = 3'd0;
    in_if.operand = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_extremes();
    test_alu_ops();
    test_call_return();
    test_random_stream(0, 0, 300);
    test_random_stream(57, 0, 300);
    test_random_stream(0, 57, 300);
    test_random_stream(18, 18, 300);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("stack_machine_executor verification clean");
    end else begin
      $display("stack_machine_executor verification failed");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/sme_pkg.sv
hdl/sme_in_if.sv
hdl/sme_out_if.sv
hdl/stack_machine_executor.sv
hdl/sme_checker.sv
tb/tb_stack_machine_executor.sv
